FILE: rtl/core/pnc_pkg.sv
// Package for the 2D gradient noise classifier.
// Holds shared constants, codes and the queue item type; no dependencies.
`default_nettype none
package pnc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PERM_SIZE     = 256;
  localparam int IDX_W         = $clog2(PERM_SIZE);
  localparam int POS_W         = 24;
  localparam int NOISE_W       = 18;
  localparam int CLASS_W       = 2;
  localparam int CFG_W         = 18;
  localparam int CFG_IDX_W     = 1;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int IN_DATA_W     = 64;
  localparam int OUT_DATA_W    = 24;

  localparam logic signed [CFG_W-1:0] WATER_RST = -18'sd32768;
  localparam logic signed [CFG_W-1:0] GRASS_RST = 18'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WATER = 1'b0,
    CFG_GRASS = 1'b1
  } cfg_idx_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_WATER = 2'd0,
    CLS_GRASS = 2'd1,
    CLS_ROCK  = 2'd2
  } class_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_t;

  typedef struct packed {
    logic             is_eval;
    logic [IDX_W-1:0] tbl_idx;
    logic [IDX_W-1:0] tbl_val;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
  } item_t;

endpackage
`default_nettype wire

FILE: rtl/core/pnc_front.sv
// Front end: takes input transfers, decodes the action and queues items.
// Depends on pnc_pkg.
`default_nettype none
module pnc_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [pnc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                              in_tuser,
  input  wire logic                              pop,
  output logic                                   q_valid,
  output pnc_pkg::item_t                         q_item
);

  pnc_pkg::item_t              queue_mem [pnc_pkg::QUEUE_DEPTH];
  logic [pnc_pkg::QPTR_W-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [pnc_pkg::QPTR_W:0]    count_r, count_nxt;
  pnc_pkg::item_t              item_in;
  logic                        push, do_pop;

  always_comb begin
    item_in.is_eval = (pnc_pkg::action_t'(in_tuser) == pnc_pkg::ACT_EVAL);
    item_in.tbl_idx = in_tdata[7:0];
    item_in.tbl_val = in_tdata[15:8];
    item_in.x_pos   = in_tdata[39:16];
    item_in.y_pos   = in_tdata[63:40];
  end

  assign in_tready = (count_r != (pnc_pkg::QPTR_W+1)'(pnc_pkg::QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_item    = queue_mem[rptr_r];
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && q_valid;

  always_comb begin
    wptr_nxt  = push   ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pnc_fade.sv
// Quintic fade curve 6t^5 - 15t^4 + 10t^3, five register stages, four multiplies.
// Depends on nothing but its parameter.
`default_nettype none
module pnc_fade #(
  parameter int F = 16
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [F-1:0] t,
  output logic      [F:0]   u
);

  localparam int PW = F + 5;
  localparam int MW = 2 * F + 6;
  localparam logic signed [PW-1:0] C15  = PW'(15) <<< F;
  localparam logic signed [PW-1:0] C10  = PW'(10) <<< F;
  localparam logic signed [PW-1:0] ONE  = PW'(1) <<< F;
  localparam logic signed [MW-1:0] HALF = MW'(1) <<< (F - 1);

  logic [F-1:0]           t1_r, t2_r, t3_r, t4_r;
  logic signed [PW-1:0]   q0_r, p1_r, p2_r, p3_r;
  logic signed [PW-1:0]   tq, q0_nxt, p1_nxt, p2_nxt, p3_nxt, p4;
  logic signed [MW-1:0]   m1, m2, m3, m4;
  logic [F:0]             u_nxt;

  assign tq     = $signed({5'b0, t});
  assign q0_nxt = (tq <<< 2) + (tq <<< 1) - C15;

  assign m1 = $signed({1'b0, t1_r}) * q0_r + HALF;
  assign m2 = $signed({1'b0, t2_r}) * p1_r + HALF;
  assign m3 = $signed({1'b0, t3_r}) * p2_r + HALF;
  assign m4 = $signed({1'b0, t4_r}) * p3_r + HALF;

  assign p1_nxt = $signed(m1[2*F+4:F]) + C10;
  assign p2_nxt = $signed(m2[2*F+4:F]);
  assign p3_nxt = $signed(m3[2*F+4:F]);
  assign p4     = $signed(m4[2*F+4:F]);

  always_comb begin
    if (p4 < 0) begin
      u_nxt = '0;
    end else if (p4 > ONE) begin
      u_nxt = (F+1)'(ONE);
    end else begin
      u_nxt = p4[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t;
      q0_r <= q0_nxt;
      t2_r <= t1_r;
      p1_r <= p1_nxt;
      t3_r <= t2_r;
      p2_r <= p2_nxt;
      t4_r <= t3_r;
      p3_r <= p3_nxt;
      u    <= u_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pnc_back.sv
// Back end: permutation lookups, gradients, blend, saturation and class.
// Depends on pnc_pkg and pnc_fade.
`default_nettype none
module pnc_back #(
  parameter int F = pnc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  input  wire pnc_pkg::item_t                      q_item,
  output logic                                     pop,
  input  wire logic signed [pnc_pkg::CFG_W-1:0]    water_limit,
  input  wire logic signed [pnc_pkg::CFG_W-1:0]    grass_limit,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [pnc_pkg::OUT_DATA_W-1:0]           out_tdata
);

  localparam int IW = pnc_pkg::IDX_W;
  localparam int NW = pnc_pkg::NOISE_W;
  localparam int SW = (F + 5 > NW) ? F + 5 : NW;
  localparam logic signed [F+1:0]   ONE2  = (F+2)'(1) <<< F;
  localparam logic signed [2*F+5:0] HALF6 = (2*F+6)'(1) <<< (F - 1);
  localparam logic signed [2*F+6:0] HALF7 = (2*F+7)'(1) <<< (F - 1);
  localparam logic signed [SW-1:0]  NMIN  = {{(SW-NW+1){1'b1}}, {(NW-1){1'b0}}};
  localparam logic signed [SW-1:0]  NMAX  = {{(SW-NW+1){1'b0}}, {(NW-1){1'b1}}};

  function automatic logic signed [F+2:0] grad(input logic [3:0] h,
                                               input logic signed [F+1:0] x,
                                               input logic signed [F+1:0] y);
    logic signed [F+2:0] gu, gv;
    gu = h[3] ? y : x;
    if (h < 4'd4) begin
      gv = y;
    end else if (h inside {4'd12, 4'd14}) begin
      gv = x;
    end else begin
      gv = '0;
    end
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  logic en;
  logic [IW-1:0] perm_a_mem [pnc_pkg::PERM_SIZE];
  logic [IW-1:0] perm_b_mem [pnc_pkg::PERM_SIZE];
  logic [IW-1:0] perm_c_mem [pnc_pkg::PERM_SIZE];

  // stage A: lattice x lookups
  logic          va_r, ea_r;
  logic [IW-1:0] ia_r, wa_r, yia_r, pa0_r, pa1_r;
  logic [F-1:0]  xfa_r, yfa_r;
  logic [IW-1:0] xi_q, yi_q;
  logic [pnc_pkg::POS_W+IW-1:0] xe, ye;
  // stage B: corner hashes
  logic          vb_r;
  logic [IW-1:0] ha_a, hb_a;
  logic [IW-1:0] haa_r, hab_r, hba_r, hbb_r;
  logic [F-1:0]  xfb_r, yfb_r;
  // stage C..E: gradients
  logic                vc_r, vd_r, ve_r;
  logic signed [F+2:0] g00_r[3], g10_r[3], g01_r[3], g11_r[3];
  logic signed [F+1:0] gx0, gx1, gy0, gy1;
  // stage F, G
  logic [F:0]          u, v, v_r;
  logic                vf_r, vg_r;
  logic signed [F+3:0] n0_r, n1_r, d0, d1;
  logic signed [2*F+5:0] pr0, pr1;
  logic signed [F+4:0] dn, n;
  logic signed [2*F+6:0] prn;
  logic signed [SW-1:0] nx;
  logic signed [NW-1:0] ng_r, nsat;
  pnc_pkg::class_t      cls;

  assign en  = !out_tvalid || out_tready;
  assign pop = en;

  assign xe   = {{IW{1'b0}}, q_item.x_pos};
  assign ye   = {{IW{1'b0}}, q_item.y_pos};
  assign xi_q = xe[F +: IW];
  assign yi_q = ye[F +: IW];

  // each copy of the table is written at the stage that reads it, keeping item order
  always_ff @(posedge clk) begin
    if (en && q_valid) begin
      if (!q_item.is_eval) begin
        perm_a_mem[q_item.tbl_idx] <= q_item.tbl_val;
      end
      pa0_r <= perm_a_mem[xi_q];
      pa1_r <= perm_a_mem[xi_q + 1'b1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ia_r  <= q_item.tbl_idx;
      wa_r  <= q_item.tbl_val;
      yia_r <= yi_q;
      xfa_r <= q_item.x_pos[F-1:0];
      yfa_r <= q_item.y_pos[F-1:0];
    end
  end

  assign ha_a = pa0_r + yia_r;
  assign hb_a = pa1_r + yia_r;

  always_ff @(posedge clk) begin
    if (en && va_r) begin
      if (!ea_r) begin
        perm_b_mem[ia_r] <= wa_r;
        perm_c_mem[ia_r] <= wa_r;
      end
      haa_r <= perm_b_mem[ha_a];
      hab_r <= perm_b_mem[ha_a + 1'b1];
      hba_r <= perm_c_mem[hb_a];
      hbb_r <= perm_c_mem[hb_a + 1'b1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xfb_r <= xfa_r;
      yfb_r <= yfa_r;
    end
  end

  assign gx0 = $signed({2'b0, xfb_r});
  assign gy0 = $signed({2'b0, yfb_r});
  assign gx1 = gx0 - ONE2;
  assign gy1 = gy0 - ONE2;

  always_ff @(posedge clk) begin
    if (en) begin
      g00_r[0] <= grad(haa_r[3:0], gx0, gy0);
      g10_r[0] <= grad(hba_r[3:0], gx1, gy0);
      g01_r[0] <= grad(hab_r[3:0], gx0, gy1);
      g11_r[0] <= grad(hbb_r[3:0], gx1, gy1);
      for (int i = 1; i < 3; i++) begin
        g00_r[i] <= g00_r[i-1];
        g10_r[i] <= g10_r[i-1];
        g01_r[i] <= g01_r[i-1];
        g11_r[i] <= g11_r[i-1];
      end
    end
  end

  pnc_fade #(.F(F)) u_fade_x (
    .clk (clk), .en (en), .t (q_item.x_pos[F-1:0]), .u (u)
  );
  pnc_fade #(.F(F)) u_fade_y (
    .clk (clk), .en (en), .t (q_item.y_pos[F-1:0]), .u (v)
  );

  assign d0  = g10_r[2] - g00_r[2];
  assign d1  = g11_r[2] - g01_r[2];
  assign pr0 = $signed({1'b0, u}) * d0 + HALF6;
  assign pr1 = $signed({1'b0, u}) * d1 + HALF6;

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r <= g00_r[2] + $signed(pr0[2*F+3:F]);
      n1_r <= g01_r[2] + $signed(pr1[2*F+3:F]);
      v_r  <= v;
    end
  end

  assign dn  = n1_r - n0_r;
  assign prn = $signed({1'b0, v_r}) * dn + HALF7;
  assign n   = n0_r + $signed(prn[2*F+4:F]);
  assign nx  = n;

  always_comb begin
    if (nx < NMIN) begin
      nsat = NMIN[NW-1:0];
    end else if (nx > NMAX) begin
      nsat = NMAX[NW-1:0];
    end else begin
      nsat = nx[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ng_r <= nsat;
    end
  end

  // water test first, so crossed limits never yield grass
  always_comb begin
    if (ng_r < water_limit) begin
      cls = pnc_pkg::CLS_WATER;
    end else if (ng_r < grass_limit) begin
      cls = pnc_pkg::CLS_GRASS;
    end else begin
      cls = pnc_pkg::CLS_ROCK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {{(pnc_pkg::OUT_DATA_W-NW-pnc_pkg::CLASS_W){1'b0}}, cls, ng_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r       <= 1'b0;
      ea_r       <= 1'b0;
      vb_r       <= 1'b0;
      vc_r       <= 1'b0;
      vd_r       <= 1'b0;
      ve_r       <= 1'b0;
      vf_r       <= 1'b0;
      vg_r       <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      va_r       <= q_valid;
      ea_r       <= q_item.is_eval;
      vb_r       <= va_r && ea_r;
      vc_r       <= vb_r;
      vd_r       <= vc_r;
      ve_r       <= vd_r;
      vf_r       <= ve_r;
      vg_r       <= vf_r;
      out_tvalid <= vg_r;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/perlin_noise_2d_classifier.sv
// Top level of the 2D gradient noise classifier with threshold registers.
// Depends on pnc_pkg, pnc_front, pnc_back (and pnc_fade below it).
//
// Takes one item per clock while the queue is not full: table writes and
// noise points share the input stream and are handled in order. The
// eight-stage back pipeline (table lookups, four-multiply fade, two lerp
// stages, class) computes each point's result. A four-entry queue separates
// input and back end; the whole back pipeline holds only while a finished
// result waits in the output register.
// No clearing pass: table entries must be written before any point reads them.
`default_nettype none
module perlin_noise_2d_classifier #(
  parameter int FRAC_BITS = pnc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [7:0] table_index, [15:8] table_value, [39:16] x_pos, [63:40] y_pos
  input  wire logic [pnc_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] action
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [17:0] noise_value, [19:18] terrain_class, [23:20] zero
  output logic [pnc_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [pnc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pnc_pkg::CFG_W-1:0]         cfg_wdata
);

  logic                                 q_valid, pop;
  pnc_pkg::item_t                       q_item;
  logic signed [pnc_pkg::CFG_W-1:0]     water_r, water_nxt, grass_r, grass_nxt;

  always_comb begin
    water_nxt = water_r;
    grass_nxt = grass_r;
    if (cfg_we) begin
      case (pnc_pkg::cfg_idx_t'(cfg_index))
        pnc_pkg::CFG_WATER: water_nxt = $signed(cfg_wdata);
        pnc_pkg::CFG_GRASS: grass_nxt = $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      water_r <= pnc_pkg::WATER_RST;
      grass_r <= pnc_pkg::GRASS_RST;
    end else begin
      water_r <= water_nxt;
      grass_r <= grass_nxt;
    end
  end

  pnc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  pnc_back #(.F(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .water_limit (water_r),
    .grass_limit (grass_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

FILE: rtl/core/pnc_checker.sv
// Port-level checker for the noise classifier, bound to the top level.
// Depends on pnc_pkg; keeps a shadow of the threshold registers.
`default_nettype none
module pnc_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [pnc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire logic                              cfg_we,
  input wire logic [pnc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire logic [pnc_pkg::CFG_W-1:0]         cfg_wdata
);

  logic signed [pnc_pkg::CFG_W-1:0]   water_r, grass_r;
  logic signed [pnc_pkg::NOISE_W-1:0] noise;
  logic [pnc_pkg::CLASS_W-1:0]        cls;

  assign noise = $signed(out_tdata[17:0]);
  assign cls   = out_tdata[19:18];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      water_r <= pnc_pkg::WATER_RST;
      grass_r <= pnc_pkg::GRASS_RST;
    end else if (cfg_we) begin
      if (cfg_index == pnc_pkg::CFG_WATER) water_r <= $signed(cfg_wdata);
      if (cfg_index == pnc_pkg::CFG_GRASS) grass_r <= $signed(cfg_wdata);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_water: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((cls == pnc_pkg::CLS_WATER) == (noise < water_r)))
    else $error("water class disagrees with limit");

  a_grass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && cls != pnc_pkg::CLS_WATER |->
      ((cls == pnc_pkg::CLS_GRASS) == (noise < grass_r)))
    else $error("grass/rock class disagrees with limit");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:20] == 4'd0)
    else $error("padding bits set");

endmodule

bind perlin_noise_2d_classifier pnc_checker u_pnc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index),
  .cfg_wdata  (cfg_wdata)
);
`default_nettype wire
